// ----- hdl/manchester_frame_transmitter_core_defines.svh -----
// Assertion macros used by the Manchester frame transmitter sequencer.
`ifndef MANCHESTER_FRAME_TRANSMITTER_CORE_DEFINES_SVH
`define MANCHESTER_FRAME_TRANSMITTER_CORE_DEFINES_SVH

// Check a property outside reset.
`define MFX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define MFX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mfx_pkg.sv -----
// Shared types and constants of the Manchester frame transmitter.
package mfx_pkg;

  localparam int MSG_BYTES_DEF = 8;
  localparam int REG_W = 8;

  localparam logic [REG_W-1:0] ZERO_COUNT_RST = 8'd14;
  localparam logic [REG_W-1:0] ONE_COUNT_RST  = 8'd4;
  localparam logic [REG_W-1:0] TRAILER_RST    = 8'd4;

  localparam logic [1:0] REG_ZERO_COUNT = 2'd0;
  localparam logic [1:0] REG_ONE_COUNT  = 2'd1;
  localparam logic [1:0] REG_TRAILER    = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ZEROES  = 3'd1,
    PH_ONES    = 3'd2,
    PH_MESSAGE = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] zero_count;
    logic [REG_W-1:0] one_count;
    logic [REG_W-1:0] trailer_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic frame_done;
  } result_t;

endpackage

// ----- hdl/manchester_frame_transmitter_core.sv -----
// A result is in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; a new item enters in the cycle the waiting result
// is taken, and input stalls while a result waits. The message store is a
// registered-read RAM read ahead at the next byte pointer, with a write
// bypass for a load to the slot being fetched.
// Reset: registers return to 14/4/4, the sequencer idles with the line low; the
// message store is not cleared.
module manchester_frame_transmitter_core #(
  parameter int MSG_BYTES = mfx_pkg::MSG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [2:0] byte_slot,
  input  logic [7:0] byte_value,
  input  logic [3:0] msg_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       line_level,
  output logic       busy_res,
  output logic       frame_done,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

  mfx_pkg::cfg_t    cfg;
  mfx_pkg::result_t res, res_q;

  logic          acc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    cur_byte;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_count    <= mfx_pkg::ZERO_COUNT_RST;
      cfg.one_count     <= mfx_pkg::ONE_COUNT_RST;
      cfg.trailer_ticks <= mfx_pkg::TRAILER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfx_pkg::REG_ZERO_COUNT: cfg.zero_count    <= cfg_data;
        mfx_pkg::REG_ONE_COUNT:  cfg.one_count     <= cfg_data;
        mfx_pkg::REG_TRAILER:    cfg.trailer_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Drop loads to slots beyond the store.
  assign ram_we    = acc && (kind == mfx_pkg::KIND_LOAD) &&
                     ({6'd0, byte_slot} < 9'(MSG_BYTES));
  assign ram_waddr = AW'(byte_slot);

  mfx_ram #(
    .WIDTH(8),
    .DEPTH(MSG_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(byte_value),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Forward a write that hits the address fetched in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (ram_waddr == rd_addr);
    end
    fwd_data <= byte_value;
  end

  assign cur_byte = fwd_hit ? fwd_data : ram_rdata;

  mfx_seq #(
    .MSG_BYTES(MSG_BYTES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .item_kind(kind),
    .item_len (msg_length),
    .cfg      (cfg),
    .cur_byte (cur_byte),
    .rd_addr  (rd_addr),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (acc) begin
      res_q <= res;
    end
  end

  assign line_level = res_q.line_level;
  assign busy_res   = res_q.busy;
  assign frame_done = res_q.frame_done;

endmodule

// ----- hdl/mfx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mfx_seq.sv -----
// Frame sequencer: phase state, symbol counters and the half-bit line level.
`include "manchester_frame_transmitter_core_defines.svh"

module mfx_seq #(
  parameter int MSG_BYTES = mfx_pkg::MSG_BYTES_DEF,
  localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic [1:0]       item_kind,
  input  logic [3:0]       item_len,
  input  mfx_pkg::cfg_t    cfg,
  input  logic [7:0]       cur_byte,
  output logic [AW-1:0]    rd_addr,
  output mfx_pkg::result_t res
);

  mfx_pkg::phase_t phase, phase_next;
  logic            second_half, second_half_next;
  logic [7:0]      remaining, remaining_next;
  logic [AW-1:0]   byte_pointer, byte_pointer_next;
  logic [2:0]      bit_position, bit_position_next;
  logic            held_level, held_level_next;
  logic [3:0]      send_length, send_length_next;

  logic       tick_level;
  logic       tick_done;
  logic       msg_bit;
  logic [7:0] rem_dec;
  logic [3:0] len_sat;

  assign msg_bit = cur_byte[bit_position];
  assign rem_dec = remaining - 8'd1;
  assign len_sat = ({5'd0, item_len} > 9'(MSG_BYTES)) ? 4'(MSG_BYTES) : item_len;

  // Level driven by a tick in the current phase.
  always_comb begin
    tick_level = 1'b0;
    tick_done  = 1'b0;
    case (phase)
      mfx_pkg::PH_IDLE:    tick_level = 1'b0;
      mfx_pkg::PH_ZEROES:  tick_level = ~second_half;
      mfx_pkg::PH_ONES:    tick_level = second_half;
      mfx_pkg::PH_MESSAGE: tick_level = msg_bit ? second_half : ~second_half;
      mfx_pkg::PH_TRAILER: begin
        tick_level = second_half;
        tick_done  = (rem_dec == 8'd0);
      end
      default:             tick_level = 1'b0;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    second_half_next  = second_half;
    remaining_next    = remaining;
    byte_pointer_next = byte_pointer;
    bit_position_next = bit_position;
    held_level_next   = held_level;
    send_length_next  = send_length;
    if (acc) begin
      case (item_kind)
        mfx_pkg::KIND_TICK: begin
          held_level_next = tick_level;
          case (phase)
            mfx_pkg::PH_IDLE: ;
            mfx_pkg::PH_ZEROES: begin
              if (second_half) begin
                second_half_next = 1'b0;
                remaining_next   = rem_dec;
                if (rem_dec == 8'd0) begin
                  phase_next     = mfx_pkg::PH_ONES;
                  remaining_next = cfg.one_count;
                end
              end else begin
                second_half_next = 1'b1;
              end
            end
            mfx_pkg::PH_ONES: begin
              if (second_half) begin
                second_half_next = 1'b0;
                remaining_next   = rem_dec;
                if (rem_dec == 8'd0) begin
                  phase_next     = mfx_pkg::PH_MESSAGE;
                  remaining_next = 8'(send_length);
                end
              end else begin
                second_half_next = 1'b1;
              end
            end
            mfx_pkg::PH_MESSAGE: begin
              if (second_half) begin
                second_half_next = 1'b0;
                if (bit_position == 3'd7) begin
                  bit_position_next = 3'd0;
                  byte_pointer_next = byte_pointer + AW'(1);
                  remaining_next    = rem_dec;
                  if (rem_dec == 8'd0) begin
                    // trailer holds the inverse of the last half-bit
                    phase_next       = mfx_pkg::PH_TRAILER;
                    remaining_next   = cfg.trailer_ticks;
                    second_half_next = ~tick_level;
                  end
                end else begin
                  bit_position_next = bit_position + 3'd1;
                end
              end else begin
                second_half_next = 1'b1;
              end
            end
            mfx_pkg::PH_TRAILER: begin
              remaining_next = rem_dec;
              if (rem_dec == 8'd0) begin
                phase_next       = mfx_pkg::PH_IDLE;
                second_half_next = 1'b0;
              end
            end
            default: phase_next = mfx_pkg::PH_IDLE;
          endcase
        end
        mfx_pkg::KIND_START: begin
          phase_next        = mfx_pkg::PH_IDLE;
          second_half_next  = 1'b0;
          remaining_next    = 8'd0;
          byte_pointer_next = '0;
          bit_position_next = 3'd0;
          send_length_next  = len_sat;
          if (len_sat != 4'd0) begin
            phase_next     = mfx_pkg::PH_ZEROES;
            remaining_next = cfg.zero_count;
          end
        end
        default: ;
      endcase
    end
  end

  // Fetch the byte the pointer will hold after this edge.
  assign rd_addr = rst ? '0 : byte_pointer_next;

  assign res.line_level = held_level_next;
  assign res.busy       = (phase_next != mfx_pkg::PH_IDLE);
  assign res.frame_done = acc && (item_kind == mfx_pkg::KIND_TICK) && tick_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mfx_pkg::PH_IDLE;
      second_half  <= 1'b0;
      remaining    <= 8'd0;
      byte_pointer <= '0;
      bit_position <= 3'd0;
      held_level   <= 1'b0;
      send_length  <= 4'd0;
    end else begin
      phase        <= phase_next;
      second_half  <= second_half_next;
      remaining    <= remaining_next;
      byte_pointer <= byte_pointer_next;
      bit_position <= bit_position_next;
      held_level   <= held_level_next;
      send_length  <= send_length_next;
    end
  end

  `MFX_ASSERT_ALWAYS(a_reset_idle, rst |=> (phase == mfx_pkg::PH_IDLE && !held_level), "not idle after reset")
  `MFX_ASSERT(a_zero_len_idle, (acc && item_kind == mfx_pkg::KIND_START && item_len == 4'd0) |=> (phase == mfx_pkg::PH_IDLE), "zero length start left a frame running")
  `MFX_ASSERT(a_trailer_end, (acc && item_kind == mfx_pkg::KIND_TICK && phase == mfx_pkg::PH_TRAILER && remaining == 8'd1) |=> (phase == mfx_pkg::PH_IDLE && !second_half), "trailer did not end")
  `MFX_ASSERT(a_bitpos_msg_only, (phase != mfx_pkg::PH_MESSAGE) |-> (bit_position == 3'd0), "bit position nonzero outside message")
  `MFX_ASSERT(a_trailer_inverse, (phase == mfx_pkg::PH_TRAILER && $past(phase) == mfx_pkg::PH_MESSAGE) |-> (second_half != held_level), "trailer level not inverted")

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the Manchester frame transmitter core.
`timescale 1ns / 100ps

module tb_top;

  // Kind code with no defined operation; the block must report the held level.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] value;
    logic [3:0] length;
    bit         hold;
  } stim_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = mfx_pkg::KIND_TICK;
  logic [2:0] byte_slot = 3'd0;
  logic [7:0] byte_value = 8'd0;
  logic [3:0] msg_length = 4'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       line_level;
  logic       busy_res;
  logic       frame_done;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = mfx_pkg::REG_ZERO_COUNT;
  logic [7:0] cfg_data = 8'd0;

  manchester_frame_transmitter_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .byte_slot  (byte_slot),
    .byte_value (byte_value),
    .msg_length (msg_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_level (line_level),
    .busy_res   (busy_res),
    .frame_done (frame_done),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the transmitter state and registers.
  logic [7:0]      zero_cnt_reg = mfx_pkg::ZERO_COUNT_RST;
  logic [7:0]      one_cnt_reg  = mfx_pkg::ONE_COUNT_RST;
  logic [7:0]      trailer_reg  = mfx_pkg::TRAILER_RST;
  mfx_pkg::phase_t ph = mfx_pkg::PH_IDLE;
  logic            sh = 1'b0;
  logic [7:0]      rem = 8'd0;
  logic [2:0]      byte_ptr = 3'd0;
  logic [2:0]      bit_pos = 3'd0;
  logic [7:0]      msg_store [mfx_pkg::MSG_BYTES_DEF];
  logic            held = 1'b0;
  logic [3:0]      send_len = 4'd0;

  stim_item_t       tx_items[$];
  mfx_pkg::result_t levels_due[$];
  stim_item_t       drv_item;
  logic             in_took = 1'b0;
  int               snd_idle = 0;
  int               rcv_idle = 0;
  int               stim_count = 0;
  int               mismatches = 0;
  int               frames_seen = 0;

  function automatic void count_symbol(mfx_pkg::phase_t nxt, logic [7:0] cnt);
    if (sh) begin
      sh = 1'b0;
      rem = rem - 8'd1;
      if (rem == 8'd0) begin
        ph = nxt;
        rem = cnt;
      end
    end else begin
      sh = 1'b1;
    end
  endfunction

  function automatic mfx_pkg::result_t line_step(logic [1:0] k, logic [2:0] s,
                                                 logic [7:0] v, logic [3:0] l);
    logic             lvl;
    logic             fin;
    logic [7:0]       cur_byte;
    logic             data_bit;
    mfx_pkg::result_t r;
    lvl = 1'b0;
    fin = 1'b0;
    if (k == mfx_pkg::KIND_TICK) begin
      case (ph)
        mfx_pkg::PH_ZEROES: begin
          lvl = ~sh;
          count_symbol(mfx_pkg::PH_ONES, one_cnt_reg);
        end
        mfx_pkg::PH_ONES: begin
          lvl = sh;
          count_symbol(mfx_pkg::PH_MESSAGE, {4'd0, send_len});
        end
        mfx_pkg::PH_MESSAGE: begin
          cur_byte = msg_store[byte_ptr];
          data_bit = cur_byte[bit_pos];
          lvl = data_bit ? sh : ~sh;
          if (sh) begin
            sh = 1'b0;
            if (bit_pos == 3'd7) begin
              bit_pos = 3'd0;
              byte_ptr = byte_ptr + 3'd1;
              rem = rem - 8'd1;
              if (rem == 8'd0) begin
                // hold the inverse of the last half-bit through the trailer
                ph = mfx_pkg::PH_TRAILER;
                rem = trailer_reg;
                sh = ~lvl;
              end
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end else begin
            sh = 1'b1;
          end
        end
        mfx_pkg::PH_TRAILER: begin
          lvl = sh;
          rem = rem - 8'd1;
          if (rem == 8'd0) begin
            ph = mfx_pkg::PH_IDLE;
            sh = 1'b0;
            fin = 1'b1;
          end
        end
        default: begin
          lvl = 1'b0;
          ph = mfx_pkg::PH_IDLE;
        end
      endcase
      held = lvl;
    end else if (k == mfx_pkg::KIND_LOAD) begin
      msg_store[s] = v;
    end else if (k == mfx_pkg::KIND_START) begin
      ph = mfx_pkg::PH_IDLE;
      sh = 1'b0;
      rem = 8'd0;
      byte_ptr = 3'd0;
      bit_pos = 3'd0;
      send_len = (l > mfx_pkg::MSG_BYTES_DEF) ? 4'(mfx_pkg::MSG_BYTES_DEF) : l;
      if (send_len != 4'd0) begin
        ph = mfx_pkg::PH_ZEROES;
        rem = zero_cnt_reg;
      end
    end
    r.line_level = held;
    r.busy = (ph != mfx_pkg::PH_IDLE);
    r.frame_done = fin;
    return r;
  endfunction

  // Input monitor, predictor and result checker.
  always @(posedge clk) begin
    mfx_pkg::result_t want;
    mfx_pkg::result_t got;
    in_took = in_valid && in_ready;
    if (!rst) begin
      if (in_took)
        levels_due.push_back(line_step(kind, byte_slot, byte_value, msg_length));
      if (out_valid && out_ready) begin
        got.line_level = line_level;
        got.busy = busy_res;
        got.frame_done = frame_done;
        if (frame_done === 1'b1)
          frames_seen++;
        if (levels_due.size() == 0) begin
          $error("result with nothing expected: line_level %0b busy_res %0b frame_done %0b",
                 line_level, busy_res, frame_done);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (got.line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
            mismatches++;
          end
          if (got.busy !== want.busy) begin
            $error("busy_res: expected %0b, got %0b", want.busy, got.busy);
            mismatches++;
          end
          if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            mismatches++;
          end
        end
      end
    end
  end

  // Driver: present the next item once the current one is taken.
  always @(negedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
      if (!in_valid || in_took) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= snd_idle &&
            !(tx_items[0].hold && levels_due.size() != 0)) begin
          drv_item = tx_items.pop_front();
          in_valid <= 1'b1;
          kind <= drv_item.kind;
          byte_slot <= drv_item.slot;
          byte_value <= drv_item.value;
          msg_length <= drv_item.length;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_item(logic [1:0] k, logic [2:0] s, logic [7:0] v, logic [3:0] l,
                           bit h);
    stim_item_t it;
    it.kind = k;
    it.slot = s;
    it.value = v;
    it.length = l;
    it.hold = h;
    tx_items.push_back(it);
    stim_count++;
  endtask

  function automatic int reg_span(logic [7:0] v);
    return (v == 8'd0) ? 256 : int'(v);
  endfunction

  // Start a frame and tick through it, with loads and stray items mixed in.
  task automatic frame_seq(int len, bit cut);
    int n_bytes;
    int total;
    int r;
    n_bytes = (len > mfx_pkg::MSG_BYTES_DEF) ? mfx_pkg::MSG_BYTES_DEF : len;
    push_item(mfx_pkg::KIND_START, 3'($urandom), 8'($urandom), 4'(len), 1'b0);
    if (n_bytes == 0)
      total = 2;
    else
      total = 2 * (reg_span(zero_cnt_reg) + reg_span(one_cnt_reg)) + 16 * n_bytes +
              reg_span(trailer_reg);
    if (cut)
      total = $urandom_range(total, 1);
    total += $urandom_range(3, 0);
    for (int i = 0; i < total; i++) begin
      r = $urandom_range(199);
      if (r < 4)
        push_item(mfx_pkg::KIND_LOAD, 3'($urandom), 8'($urandom), 4'($urandom), 1'b0);
      else if (r < 6)
        push_item(KIND_SPARE, 3'($urandom), 8'($urandom), 4'($urandom), 1'b0);
      push_item(mfx_pkg::KIND_TICK, 3'($urandom), 8'($urandom), 4'($urandom), r == 7);
    end
  endtask

  task automatic gen_random(int budget);
    int first;
    int r;
    int lr;
    first = stim_count;
    while (stim_count - first < budget) begin
      r = $urandom_range(99);
      lr = $urandom_range(99);
      if (r < 6)
        push_item(2'($urandom_range(3, 0)), 3'($urandom), 8'($urandom), 4'($urandom),
                  1'b0);
      else if (r < 16)
        frame_seq($urandom_range(15, 0), 1'b1);
      else if (lr < 8)
        frame_seq(0, 1'b0);
      else if (lr < 16)
        frame_seq($urandom_range(15, 9), 1'b0);
      else
        frame_seq($urandom_range(8, 1), 1'b0);
    end
  endtask

  task automatic set_regs(logic [7:0] zc, logic [7:0] oc, logic [7:0] tt);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mfx_pkg::REG_ZERO_COUNT;
    cfg_data <= zc;
    zero_cnt_reg = zc;
    @(negedge clk);
    cfg_index <= mfx_pkg::REG_ONE_COUNT;
    cfg_data <= oc;
    one_cnt_reg = oc;
    @(negedge clk);
    cfg_index <= mfx_pkg::REG_TRAILER;
    cfg_data <= tt;
    trailer_reg = tt;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (tx_items.size() != 0 || in_valid || levels_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle = 6;
    rcv_idle = 53;
    set_regs(8'd1, 8'd1, 8'd1);
    // Fill every slot before any frame can read the store.
    push_item(mfx_pkg::KIND_LOAD, 3'd0, 8'h00, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd1, 8'hFF, 4'd15, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd2, 8'hA5, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd3, 8'h5A, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd4, 8'h01, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd5, 8'h80, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd6, 8'h3C, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_LOAD, 3'd7, 8'hC3, 4'd0, 1'b0);
    push_item(KIND_SPARE, 3'd7, 8'hFF, 4'd15, 1'b0);
    push_item(mfx_pkg::KIND_TICK, 3'd0, 8'h00, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_START, 3'd0, 8'h00, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_TICK, 3'd7, 8'hFF, 4'd15, 1'b1);
    // Oversized length, then cancel the frame with a fresh start.
    push_item(mfx_pkg::KIND_START, 3'd7, 8'hFF, 4'd15, 1'b0);
    push_item(mfx_pkg::KIND_TICK, 3'd0, 8'h00, 4'd0, 1'b0);
    push_item(mfx_pkg::KIND_TICK, 3'd0, 8'h00, 4'd0, 1'b0);
    frame_seq(1, 1'b0);
    gen_random(200);
    drain();

    set_regs(mfx_pkg::ZERO_COUNT_RST, mfx_pkg::ONE_COUNT_RST, mfx_pkg::TRAILER_RST);
    gen_random(200);
    drain();

    snd_idle = 53;
    rcv_idle = 6;
    set_regs(8'($urandom_range(24, 2)), 8'($urandom_range(24, 2)),
             8'($urandom_range(24, 2)));
    gen_random(200);
    drain();

    // Zero count of 255 with short ones and trailer.
    set_regs(8'd255, 8'd3, 8'd2);
    frame_seq($urandom_range(2, 1), 1'b0);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    // A zero trailer count wraps to the longest hold.
    set_regs(8'd1, 8'd1, 8'd0);
    gen_random(250);
    drain();

    set_regs(8'd3, 8'd2, 8'd5);
    gen_random(250);
    drain();

    $display("Ran %0d items across six register settings and three idle patterns;",
             stim_count);
    $display("%0d frames ran to the end of their trailer.", frames_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mfx_pkg.sv
hdl/mfx_ram.sv
hdl/mfx_seq.sv
hdl/manchester_frame_transmitter_core.sv
test/tb_top.sv
